// File: src/stok_pkg.sv
// Package for the source tokenizer: token codes, scan modes and byte classes.
// No dependencies.
`timescale 1ns / 1ps

package stok_pkg;

    localparam int IndexBitsDefault    = 24;
    localparam int KeywordCharsDefault = 8;
    localparam int KeywordCount        = 25;
    localparam int KwLenMax            = 8;

    localparam logic [6:0] TK_NOT_SIGN = 7'd29;
    localparam logic [6:0] TK_KW_BASE  = 7'd45;
    localparam logic [6:0] TK_NAME     = 7'd70;
    localparam logic [6:0] TK_LIT      = 7'd71;
    localparam logic [6:0] TK_END      = 7'd72;
    localparam logic [6:0] TK_BAD      = 7'd73;
    localparam logic [6:0] TK_NONE     = 7'd127;

    localparam logic [2:0] LIT_NONE  = 3'd0;
    localparam logic [2:0] LIT_INT   = 3'd1;
    localparam logic [2:0] LIT_FLOAT = 3'd2;
    localparam logic [2:0] LIT_STR   = 3'd3;
    localparam logic [2:0] LIT_CHAR  = 3'd4;

    localparam logic [0:0] REG_FIRST_LINE = 1'b0;
    localparam logic [0:0] REG_FIRST_COL  = 1'b1;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_WORD, M_INT, M_FRAC, M_OP, M_STR,
        M_CH_OPEN, M_CH_ESC, M_CH_BODY
    } scan_mode_t;

    typedef logic [KwLenMax*8-1:0] kw_text_t;

    typedef struct packed {
        logic [6:0] kind;
        logic [2:0] lit;
    } tok_code_t;

    function automatic kw_text_t kw_text(input int i);
        kw_text_t t;
        t = '0;
        unique case (i)
            0:  t = {"fun",      40'd0};
            1:  t = {"proc",     32'd0};
            2:  t = {"domain",   16'd0};
            3:  t = {"of",       48'd0};
            4:  t = {"spawn",    24'd0};
            5:  t = {"if",       48'd0};
            6:  t = {"else",     32'd0};
            7:  t = {"for",      40'd0};
            8:  t = {"while",    24'd0};
            9:  t = {"until",    24'd0};
            10: t = {"in",       48'd0};
            11: t = {"pod",      40'd0};
            12: t = {"return",   16'd0};
            13: t = {"true",     32'd0};
            14: t = {"false",    24'd0};
            15: t = {"ref",      40'd0};
            16: t = {"bind",     32'd0};
            17: t = {"loop",     32'd0};
            18: t = {"break",    24'd0};
            19: t = "continue";
            20: t = {"as",       48'd0};
            21: t = {"test",     32'd0};
            22: t = {"const",    24'd0};
            23: t = {"enum",     32'd0};
            default: t = {"switch", 16'd0};
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input int i);
        logic [3:0] n;
        unique case (i)
            0, 7, 11, 15:             n = 4'd3;
            1, 6, 13, 16, 17, 21, 23: n = 4'd4;
            2, 12, 24:                n = 4'd6;
            3, 5, 10, 20:             n = 4'd2;
            19:                       n = 4'd8;
            default:                  n = 4'd5;
        endcase
        return n;
    endfunction

    // operator byte that may start a two-byte operator; TK_NONE otherwise
    function automatic logic [6:0] alone_kind(input logic [7:0] b);
        logic [6:0] k;
        unique case (b)
            8'h7C: k = 7'd27;
            8'h3C: k = 7'd23;
            8'h3E: k = 7'd24;
            8'h3D: k = 7'd42;
            8'h21: k = 7'd28;
            8'h26: k = 7'd26;
            8'h2B: k = 7'd18;
            8'h2D: k = 7'd19;
            8'h2F: k = 7'd20;
            8'h2A: k = 7'd21;
            8'h25: k = 7'd22;
            8'h2E: k = 7'd35;
            8'h3A: k = 7'd34;
            8'hC2: k = TK_BAD;
            default: k = TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [6:0] k;
        k = TK_NONE;
        unique case (a)
            8'h7C: k = (b == 8'h21) ? 7'd0 : (b == 8'h7C) ? 7'd1 : (b == 8'h3D) ? 7'd11 : TK_NONE;
            8'h3C: k = (b == 8'h3C) ? 7'd2 : (b == 8'h3D) ? 7'd5 : TK_NONE;
            8'h3E: k = (b == 8'h3E) ? 7'd3 : (b == 8'h3D) ? 7'd4 : TK_NONE;
            8'h3D: k = (b == 8'h3D) ? 7'd6 : (b == 8'h3E) ? 7'd17 : TK_NONE;
            8'h21: k = (b == 8'h3D) ? 7'd7 : TK_NONE;
            8'h26: k = (b == 8'h26) ? 7'd8 : (b == 8'h3D) ? 7'd12 : TK_NONE;
            8'h2B: k = (b == 8'h3D) ? 7'd9 : TK_NONE;
            8'h2D: k = (b == 8'h3D) ? 7'd10 : (b == 8'h3E) ? 7'd16 : TK_NONE;
            8'h2F: k = (b == 8'h3D) ? 7'd13 : TK_NONE;
            8'h2A: k = (b == 8'h3D) ? 7'd14 : TK_NONE;
            8'h25: k = (b == 8'h3D) ? 7'd15 : TK_NONE;
            8'h2E: k = (b == 8'h2E) ? 7'd30 : TK_NONE;
            8'h3A: k = (b == 8'h3A) ? 7'd31 : TK_NONE;
            8'hC2: k = (b == 8'hAC) ? TK_NOT_SIGN : TK_NONE;
            default: k = TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] single_kind(input logic [7:0] b);
        logic [6:0] k;
        unique case (b)
            8'h7E: k = 7'd25;
            8'h2C: k = 7'd32;
            8'h3B: k = 7'd33;
            8'h7B: k = 7'd36;
            8'h7D: k = 7'd37;
            8'h28: k = 7'd38;
            8'h29: k = 7'd39;
            8'h5B: k = 7'd40;
            8'h5D: k = 7'd41;
            8'h40: k = 7'd43;
            8'h5C: k = 7'd44;
            default: k = TK_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

endpackage

// File: src/source_tokenizer_unit.sv
// Source tokenizer top level: scan state, position counters, APB registers, output queue.
// Depends on stok_pkg and stok_kw_match.
`timescale 1ns / 1ps

// Takes one byte (or the end marker) per cycle while in_ready is high and
// reports up to two tokens for it, each with start/end index, line and
// column. A byte is decided combinationally; tokens leave through a two-entry
// output queue, so a sustained rate of one byte per cycle holds while no byte
// yields two tokens and the consumer takes one token per cycle. Registers: 0
// first line number, 1 first column number (APB, byte address 4*i).
module source_tokenizer_unit #(
    parameter int INDEX_BITS    = stok_pkg::IndexBitsDefault,
    parameter int KEYWORD_CHARS = stok_pkg::KeywordCharsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  token_kind,
    output logic [2:0]  literal_kind,
    output logic [23:0] start_index,
    output logic [23:0] end_index,
    output logic [23:0] head_line,
    output logic [15:0] head_column,
    output logic [23:0] tail_line,
    output logic [15:0] tail_column,
    output logic        last
);

    localparam int LenBits = $clog2(KEYWORD_CHARS + 2);
    localparam logic [INDEX_BITS-1:0] IndexMax = '1;

    typedef struct packed {
        logic [6:0]  kind;
        logic [2:0]  lit;
        logic [23:0] s_idx;
        logic [23:0] e_idx;
        logic [23:0] s_line;
        logic [15:0] s_col;
        logic [23:0] e_line;
        logic [15:0] e_col;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic [23:0]           line;
        logic [15:0]           col;
    } pos_t;

    logic first_line_reg, first_col_reg;
    stok_pkg::scan_mode_t mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic [KEYWORD_CHARS*8-1:0] word_reg, word_next;
    logic [LenBits-1:0] wlen_reg, wlen_next;
    pos_t pos_reg, pos_next, start_reg, start_next;
    logic esc_reg, esc_next;

    tok_t q_reg [2];
    logic [1:0] qcnt_reg, qcnt_next;
    tok_t q_next [2];

    logic wr;
    logic [6:0] word_kind;

    stok_kw_match #(.KEYWORD_CHARS(KEYWORD_CHARS), .LEN_BITS(LenBits)) u_kw (
        .word(word_reg), .word_len(wlen_reg), .kind(word_kind)
    );

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == stok_pkg::REG_FIRST_COL) prdata[0] = first_col_reg;
        else                                     prdata[0] = first_line_reg;
    end

    logic accept;
    assign in_ready = (qcnt_reg == 2'd0) || (qcnt_reg == 2'd1 && out_ready);
    assign accept = in_valid && in_ready;

    function automatic logic [23:0] clamp_idx(input logic [INDEX_BITS-1:0] v);
        logic [23:0] r;
        if (INDEX_BITS > 24 && v > INDEX_BITS'(24'hFFFFFF))
            r = 24'hFFFFFF;
        else
            r = 24'(v);
        return r;
    endfunction

    function automatic pos_t take_pos(input pos_t p, input logic [7:0] b, input logic fc);
        pos_t r;
        r = p;
        if (b == 8'h0A)
        begin
            if (p.line != 24'hFFFFFF) r.line = p.line + 24'd1;
            r.col = {15'd0, fc};
        end
        else if (p.col != 16'hFFFF)
        begin
            r.col = p.col + 16'd1;
        end
        if (p.idx != IndexMax) r.idx = p.idx + 1'b1;
        return r;
    endfunction

    function automatic tok_t mk(input logic [6:0] k, input logic [2:0] l,
                                input pos_t s, input pos_t e);
        tok_t t;
        t.kind = k;
        t.lit = l;
        t.s_idx = clamp_idx(s.idx);
        t.e_idx = clamp_idx(e.idx);
        t.s_line = s.line;
        t.s_col = s.col;
        t.e_line = e.line;
        t.e_col = e.col;
        t.last = 1'b0;
        return t;
    endfunction

    tok_t t0, t1;
    logic e0, e1;

    always_comb
    begin
        logic [7:0] b;
        logic fresh;
        pos_t p;
        logic [6:0] k;
        b = byte_value;
        k = stok_pkg::TK_NONE;
        mode_next = mode_reg;
        held_next = held_reg;
        word_next = word_reg;
        wlen_next = wlen_reg;
        pos_next = pos_reg;
        start_next = start_reg;
        esc_next = esc_reg;
        e0 = 1'b0;
        e1 = 1'b0;
        t0 = mk(stok_pkg::TK_END, stok_pkg::LIT_NONE, pos_reg, pos_reg);
        t1 = t0;
        fresh = 1'b0;
        p = take_pos(pos_reg, b, first_col_reg);
        if (is_end)
        begin
            e0 = 1'b1;
            unique case (mode_reg)
                stok_pkg::M_WORD:
                    t0 = mk(word_kind, stok_pkg::LIT_NONE, start_reg, pos_reg);
                stok_pkg::M_INT:
                    t0 = mk(stok_pkg::TK_LIT, stok_pkg::LIT_INT, start_reg, pos_reg);
                stok_pkg::M_FRAC:
                    t0 = mk(stok_pkg::TK_LIT, stok_pkg::LIT_FLOAT, start_reg, pos_reg);
                stok_pkg::M_OP:
                    t0 = mk(stok_pkg::alone_kind(held_reg), stok_pkg::LIT_NONE,
                            start_reg, pos_reg);
                stok_pkg::M_STR, stok_pkg::M_CH_OPEN, stok_pkg::M_CH_ESC,
                stok_pkg::M_CH_BODY:
                    t0 = mk(stok_pkg::TK_BAD, stok_pkg::LIT_NONE, start_reg, pos_reg);
                default:
                    e0 = 1'b0;
            endcase
            e1 = e0;
            t1 = mk(stok_pkg::TK_END, stok_pkg::LIT_NONE, pos_reg, pos_reg);
            if (!e0) t0 = t1;
            e0 = 1'b1;
            mode_next = stok_pkg::M_IDLE;
            held_next = '0;
            word_next = '0;
            wlen_next = '0;
            pos_next = '{idx: '0, line: {23'd0, first_line_reg}, col: {15'd0, first_col_reg}};
            start_next = '0;
            esc_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                stok_pkg::M_COMMENT:
                begin
                    pos_next = p;
                    if (b == 8'h0A) mode_next = stok_pkg::M_IDLE;
                end
                stok_pkg::M_WORD:
                    if (stok_pkg::is_alpha(b) || stok_pkg::is_digit(b) || b == 8'h5F)
                    begin
                        for (int i = 0; i < KEYWORD_CHARS; i++)
                            if (wlen_reg == LenBits'(i))
                                word_next[(KEYWORD_CHARS-1-i)*8 +: 8] = b;
                        if (wlen_reg <= LenBits'(KEYWORD_CHARS)) wlen_next = wlen_reg + 1'b1;
                        pos_next = p;
                    end
                    else
                    begin
                        e0 = 1'b1;
                        t0 = mk(word_kind, stok_pkg::LIT_NONE, start_reg, pos_reg);
                        fresh = 1'b1;
                    end
                stok_pkg::M_INT:
                    if (stok_pkg::is_digit(b)) pos_next = p;
                    else if (b == 8'h2E)
                    begin
                        pos_next = p;
                        mode_next = stok_pkg::M_FRAC;
                    end
                    else
                    begin
                        e0 = 1'b1;
                        t0 = mk(stok_pkg::TK_LIT, stok_pkg::LIT_INT, start_reg, pos_reg);
                        fresh = 1'b1;
                    end
                stok_pkg::M_FRAC:
                    if (stok_pkg::is_digit(b)) pos_next = p;
                    else
                    begin
                        e0 = 1'b1;
                        t0 = mk(stok_pkg::TK_LIT, stok_pkg::LIT_FLOAT, start_reg, pos_reg);
                        fresh = 1'b1;
                    end
                stok_pkg::M_OP:
                begin
                    k = stok_pkg::pair_kind(held_reg, b);
                    e0 = 1'b1;
                    if (k != stok_pkg::TK_NONE)
                    begin
                        pos_next = p;
                        t0 = mk(k, stok_pkg::LIT_NONE, start_reg, p);
                        mode_next = stok_pkg::M_IDLE;
                    end
                    else
                    begin
                        t0 = mk(stok_pkg::alone_kind(held_reg), stok_pkg::LIT_NONE,
                                start_reg, pos_reg);
                        fresh = 1'b1;
                    end
                end
                stok_pkg::M_STR:
                begin
                    pos_next = p;
                    esc_next = 1'b0;
                    if (esc_reg && b == 8'h22) ;
                    else if (b == 8'h22)
                    begin
                        e0 = 1'b1;
                        t0 = mk(stok_pkg::TK_LIT, stok_pkg::LIT_STR, start_reg, p);
                        mode_next = stok_pkg::M_IDLE;
                    end
                    else if (b == 8'h0A)
                    begin
                        e0 = 1'b1;
                        t0 = mk(stok_pkg::TK_BAD, stok_pkg::LIT_NONE, start_reg, p);
                        mode_next = stok_pkg::M_IDLE;
                    end
                    else if (b == 8'h5C) esc_next = 1'b1;
                end
                stok_pkg::M_CH_OPEN:
                begin
                    pos_next = p;
                    if (b == 8'h5C) mode_next = stok_pkg::M_CH_ESC;
                    else if (b == 8'h27)
                    begin
                        e0 = 1'b1;
                        t0 = mk(stok_pkg::TK_BAD, stok_pkg::LIT_NONE, start_reg, p);
                        mode_next = stok_pkg::M_IDLE;
                    end
                    else mode_next = stok_pkg::M_CH_BODY;
                end
                stok_pkg::M_CH_ESC:
                begin
                    pos_next = p;
                    mode_next = stok_pkg::M_CH_BODY;
                end
                stok_pkg::M_CH_BODY:
                    if (b == 8'h27)
                    begin
                        pos_next = p;
                        e0 = 1'b1;
                        t0 = mk(stok_pkg::TK_LIT, stok_pkg::LIT_CHAR, start_reg, p);
                        mode_next = stok_pkg::M_IDLE;
                    end
                    else
                    begin
                        e0 = 1'b1;
                        t0 = mk(stok_pkg::TK_BAD, stok_pkg::LIT_NONE, start_reg, pos_reg);
                        fresh = 1'b1;
                    end
                default:
                    fresh = 1'b1;
            endcase

            if (fresh)
            begin
                mode_next = stok_pkg::M_IDLE;
                pos_next = p;
                if (stok_pkg::is_space(b)) ;
                else if (b == 8'h23) mode_next = stok_pkg::M_COMMENT;
                else
                begin
                    start_next = pos_reg;
                    if (stok_pkg::alone_kind(b) != stok_pkg::TK_NONE)
                    begin
                        held_next = b;
                        mode_next = stok_pkg::M_OP;
                    end
                    else if (stok_pkg::single_kind(b) != stok_pkg::TK_NONE)
                    begin
                        e1 = 1'b1;
                        t1 = mk(stok_pkg::single_kind(b), stok_pkg::LIT_NONE, pos_reg, p);
                    end
                    else if (stok_pkg::is_alpha(b) || b == 8'h5F)
                    begin
                        word_next = '0;
                        word_next[KEYWORD_CHARS*8-1 -: 8] = b;
                        wlen_next = LenBits'(1);
                        mode_next = stok_pkg::M_WORD;
                    end
                    else if (stok_pkg::is_digit(b)) mode_next = stok_pkg::M_INT;
                    else if (b == 8'h22)
                    begin
                        esc_next = 1'b0;
                        mode_next = stok_pkg::M_STR;
                    end
                    else if (b == 8'h27) mode_next = stok_pkg::M_CH_OPEN;
                    else
                    begin
                        e1 = 1'b1;
                        t1 = mk(stok_pkg::TK_BAD, stok_pkg::LIT_NONE, pos_reg, p);
                    end
                end
            end
            if (!e0 && e1)
            begin
                t0 = t1;
                e0 = 1'b1;
                e1 = 1'b0;
            end
        end
        if (e1) t1.last = 1'b1;
        else    t0.last = 1'b1;
    end

    // output queue: entry 0 is the head
    logic pop;
    assign pop = out_valid && out_ready;
    always_comb
    begin
        logic [1:0] c;
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        c = qcnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            c = c - 2'd1;
        end
        if (accept && e0)
        begin
            if (c == 2'd0)
            begin
                q_next[0] = t0;
                q_next[1] = t1;
            end
            else
            begin
                q_next[1] = t0;
            end
            c = c + (e1 ? 2'd2 : 2'd1);
        end
        qcnt_next = c;
    end

    assign out_valid = qcnt_reg != 2'd0;
    assign token_kind = q_reg[0].kind;
    assign literal_kind = q_reg[0].lit;
    assign start_index = q_reg[0].s_idx;
    assign end_index = q_reg[0].e_idx;
    assign head_line = q_reg[0].s_line;
    assign head_column = q_reg[0].s_col;
    assign tail_line = q_reg[0].e_line;
    assign tail_column = q_reg[0].e_col;
    assign last = q_reg[0].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_line_reg <= 1'b0;
            first_col_reg <= 1'b0;
            mode_reg <= stok_pkg::M_IDLE;
            held_reg <= '0;
            word_reg <= '0;
            wlen_reg <= '0;
            pos_reg <= '0;
            start_reg <= '0;
            esc_reg <= 1'b0;
            qcnt_reg <= '0;
        end
        else
        begin
            qcnt_reg <= qcnt_next;
            if (accept)
            begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                word_reg <= word_next;
                wlen_reg <= wlen_next;
                pos_reg <= pos_next;
                start_reg <= start_next;
                esc_reg <= esc_next;
            end
            if (wr)
            begin
                if (paddr[2] == stok_pkg::REG_FIRST_COL)
                begin
                    first_col_reg <= pwdata[0];
                    if (!accept && pos_reg.idx == '0) pos_reg.col <= {15'd0, pwdata[0]};
                end
                else
                begin
                    first_line_reg <= pwdata[0];
                    if (!accept && pos_reg.idx == '0) pos_reg.line <= {23'd0, pwdata[0]};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule

// File: src/stok_kw_match.sv
// Keyword matcher: compares the held word against the keyword list.
// Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_kw_match #(
    parameter int KEYWORD_CHARS = stok_pkg::KeywordCharsDefault,
    parameter int LEN_BITS      = $clog2(KEYWORD_CHARS + 2)
) (
    input  logic [KEYWORD_CHARS*8-1:0] word,
    input  logic [LEN_BITS-1:0]        word_len,
    output logic [6:0]                 kind
);

    always_comb
    begin
        logic [KEYWORD_CHARS*8-1:0] t;
        kind = stok_pkg::TK_NAME;
        for (int i = stok_pkg::KeywordCount - 1; i >= 0; i--)
        begin
            t = '0;
            t[KEYWORD_CHARS*8-1 -: stok_pkg::KwLenMax*8] = stok_pkg::kw_text(i);
            if (word == t && word_len == LEN_BITS'(stok_pkg::kw_len(i)))
            begin
                kind = stok_pkg::TK_KW_BASE + 7'(i);
            end
        end
    end

endmodule

// File: src/stok_checker.sv
// Port-level checker for source_tokenizer_unit, bound to the top level.
// Depends on source_tokenizer_unit ports.
`timescale 1ns / 1ps

module stok_assertions (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] token_kind,
    input logic [2:0] literal_kind,
    input logic [31:0] prdata
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind))
        else $error("token changed while stalled");

    a_lit_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && literal_kind != 3'd0 |-> token_kind == 7'd71)
        else $error("literal kind on non-literal");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= 7'd73 && literal_kind <= 3'd4)
        else $error("token code out of range");

    a_prdata: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:1] == 31'd0)
        else $error("reserved read bits set");

endmodule

bind source_tokenizer_unit stok_assertions u_stok_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .token_kind(token_kind),
    .literal_kind(literal_kind), .prdata(prdata)
);

// File: tb/sv/stok_checker.sv
// Token checker for source_tokenizer_unit: watches the byte, token and register channels,
// predicts the token stream and compares every token field by field.
// Depends on stok_pkg.
`timescale 1ns / 1ps

module stok_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic        is_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  token_kind,
    input  logic [2:0]  literal_kind,
    input  logic [23:0] start_index,
    input  logic [23:0] end_index,
    input  logic [23:0] head_line,
    input  logic [15:0] head_column,
    input  logic [23:0] tail_line,
    input  logic [15:0] tail_column,
    input  logic        last,
    output int          errors,
    output int          pending
);

    localparam int OpCount = 45;

    typedef struct {
        logic [6:0]  kind;
        logic [2:0]  lit;
        logic [23:0] s_idx;
        logic [23:0] e_idx;
        logic [23:0] s_line;
        logic [15:0] s_col;
        logic [23:0] e_line;
        logic [15:0] e_col;
        logic        fin;
    } token_t;

    string op_text[OpCount] = '{
        "|!", "||", "<<", ">>", ">=", "<=", "==", "!=", "&&", "+=", "-=", "|=",
        "&=", "/=", "*=", "%=", "->", "=>", "+", "-", "/", "*", "%", "<",
        ">", "~", "&", "|", "!", "??", "..", "::", ",", ";", ":", ".",
        "{", "}", "(", ")", "[", "]", "=", "@", "\\"
    };
    string keywords[stok_pkg::KeywordCount] = '{
        "fun", "proc", "domain", "of", "spawn", "if", "else", "for", "while",
        "until", "in", "pod", "return", "true", "false", "ref", "bind", "loop",
        "break", "continue", "as", "test", "const", "enum", "switch"
    };

    token_t               token_q[$];
    token_t               step_tokens[$];
    stok_pkg::scan_mode_t mode;
    logic [7:0]           held;
    logic [7:0]           word[0:stok_pkg::KwLenMax-1];
    int                   wlen;
    logic [23:0]          pos;
    logic [23:0]          line;
    logic [15:0]          col;
    logic [23:0]          tok_idx;
    logic [23:0]          tok_line;
    logic [15:0]          tok_col;
    logic                 esc;
    logic                 first_line;
    logic                 first_col;

    initial op_text[stok_pkg::TK_NOT_SIGN] = string'({8'hC2, 8'hAC});

    function void clear_scan();
        mode = stok_pkg::M_IDLE;
        held = '0;
        for (int i = 0; i < stok_pkg::KwLenMax; i++) word[i] = '0;
        wlen = 0;
        pos = '0;
        line = 24'(first_line);
        col = 16'(first_col);
        tok_idx = '0;
        tok_line = '0;
        tok_col = '0;
        esc = 1'b0;
    endfunction

    function void emit(logic [6:0] kind, logic [2:0] lit);
        token_t t;
        t.kind = kind;
        t.lit = lit;
        t.s_idx = tok_idx;
        t.e_idx = pos;
        t.s_line = tok_line;
        t.s_col = tok_col;
        t.e_line = line;
        t.e_col = col;
        t.fin = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function void advance(logic [7:0] b);
        if (b == 8'h0A) begin
            if (line != 24'hFFFFFF) line++;
            col = 16'(first_col);
        end else if (col != 16'hFFFF) begin
            col++;
        end
        if (pos != 24'hFFFFFF) pos++;
    endfunction

    function void mark();
        tok_idx = pos;
        tok_line = line;
        tok_col = col;
    endfunction

    function int op_single(logic [7:0] b);
        for (int i = 0; i < OpCount; i++)
            if (op_text[i].len() == 1 && op_text[i][0] == b) return i;
        return -1;
    endfunction

    function bit op_prefix(logic [7:0] b);
        for (int i = 0; i < OpCount; i++)
            if (op_text[i].len() == 2 && op_text[i][0] == b) return 1'b1;
        return 1'b0;
    endfunction

    function int op_pair(logic [7:0] a, logic [7:0] b);
        for (int i = 0; i < OpCount; i++)
            if (op_text[i].len() == 2 && op_text[i][0] == a && op_text[i][1] == b) return i;
        return -1;
    endfunction

    function logic [6:0] held_alone();
        if (held == 8'hC2) return stok_pkg::TK_BAD;
        return 7'(op_single(held));
    endfunction

    function bit word_char(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function bit digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function void word_add(logic [7:0] b);
        if (wlen < stok_pkg::KwLenMax) word[wlen] = b;
        if (wlen <= stok_pkg::KwLenMax) wlen++;
    endfunction

    function logic [6:0] word_kind();
        bit hit;
        if (wlen == 0 || wlen > stok_pkg::KwLenMax) return stok_pkg::TK_NAME;
        for (int k = 0; k < stok_pkg::KeywordCount; k++) begin
            if (keywords[k].len() == wlen) begin
                hit = 1'b1;
                for (int j = 0; j < wlen; j++)
                    if (keywords[k][j] != word[j]) hit = 1'b0;
                if (hit) return stok_pkg::TK_KW_BASE + 7'(k);
            end
        end
        return stok_pkg::TK_NAME;
    endfunction

    function void scan_fresh(logic [7:0] b);
        int k;
        mode = stok_pkg::M_IDLE;
        if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin
            advance(b);
            return;
        end
        if (b == "#") begin
            advance(b);
            mode = stok_pkg::M_COMMENT;
            return;
        end
        mark();
        advance(b);
        if (op_prefix(b) || b == 8'hC2) begin
            held = b;
            mode = stok_pkg::M_OP;
            return;
        end
        k = op_single(b);
        if (k >= 0) begin
            emit(7'(k), stok_pkg::LIT_NONE);
            return;
        end
        if (word_char(b)) begin
            wlen = 0;
            word_add(b);
            mode = stok_pkg::M_WORD;
        end else if (digit(b)) begin
            mode = stok_pkg::M_INT;
        end else if (b == "\"") begin
            esc = 1'b0;
            mode = stok_pkg::M_STR;
        end else if (b == "'") begin
            mode = stok_pkg::M_CH_OPEN;
        end else begin
            emit(stok_pkg::TK_BAD, stok_pkg::LIT_NONE);
        end
    endfunction

    function void scan_byte(logic [7:0] b);
        int k;
        case (mode)
            stok_pkg::M_COMMENT: begin
                advance(b);
                if (b == 8'h0A) mode = stok_pkg::M_IDLE;
            end
            stok_pkg::M_WORD: begin
                if (word_char(b) || digit(b)) begin
                    word_add(b);
                    advance(b);
                end else begin
                    emit(word_kind(), stok_pkg::LIT_NONE);
                    scan_fresh(b);
                end
            end
            stok_pkg::M_INT: begin
                if (digit(b)) advance(b);
                else if (b == ".") begin
                    advance(b);
                    mode = stok_pkg::M_FRAC;
                end else begin
                    emit(stok_pkg::TK_LIT, stok_pkg::LIT_INT);
                    scan_fresh(b);
                end
            end
            stok_pkg::M_FRAC: begin
                if (digit(b)) advance(b);
                else begin
                    emit(stok_pkg::TK_LIT, stok_pkg::LIT_FLOAT);
                    scan_fresh(b);
                end
            end
            stok_pkg::M_OP: begin
                k = op_pair(held, b);
                if (k >= 0) begin
                    advance(b);
                    emit(7'(k), stok_pkg::LIT_NONE);
                    mode = stok_pkg::M_IDLE;
                end else begin
                    emit(held_alone(), stok_pkg::LIT_NONE);
                    scan_fresh(b);
                end
            end
            stok_pkg::M_STR: begin
                if (esc && b == "\"") begin
                    esc = 1'b0;
                    advance(b);
                end else begin
                    esc = 1'b0;
                    advance(b);
                    if (b == "\"") begin
                        emit(stok_pkg::TK_LIT, stok_pkg::LIT_STR);
                        mode = stok_pkg::M_IDLE;
                    end else if (b == 8'h0A) begin
                        emit(stok_pkg::TK_BAD, stok_pkg::LIT_NONE);
                        mode = stok_pkg::M_IDLE;
                    end else if (b == "\\") begin
                        esc = 1'b1;
                    end
                end
            end
            stok_pkg::M_CH_OPEN: begin
                advance(b);
                if (b == "\\") mode = stok_pkg::M_CH_ESC;
                else if (b == "'") begin
                    emit(stok_pkg::TK_BAD, stok_pkg::LIT_NONE);
                    mode = stok_pkg::M_IDLE;
                end else mode = stok_pkg::M_CH_BODY;
            end
            stok_pkg::M_CH_ESC: begin
                advance(b);
                mode = stok_pkg::M_CH_BODY;
            end
            stok_pkg::M_CH_BODY: begin
                if (b == "'") begin
                    advance(b);
                    emit(stok_pkg::TK_LIT, stok_pkg::LIT_CHAR);
                    mode = stok_pkg::M_IDLE;
                end else begin
                    emit(stok_pkg::TK_BAD, stok_pkg::LIT_NONE);
                    scan_fresh(b);
                end
            end
            default: scan_fresh(b);
        endcase
    endfunction

    function void scan_end();
        case (mode)
            stok_pkg::M_WORD:  emit(word_kind(), stok_pkg::LIT_NONE);
            stok_pkg::M_INT:   emit(stok_pkg::TK_LIT, stok_pkg::LIT_INT);
            stok_pkg::M_FRAC:  emit(stok_pkg::TK_LIT, stok_pkg::LIT_FLOAT);
            stok_pkg::M_OP:    emit(held_alone(), stok_pkg::LIT_NONE);
            stok_pkg::M_STR, stok_pkg::M_CH_OPEN, stok_pkg::M_CH_ESC, stok_pkg::M_CH_BODY:
                emit(stok_pkg::TK_BAD, stok_pkg::LIT_NONE);
            default: ;
        endcase
        mark();
        emit(stok_pkg::TK_END, stok_pkg::LIT_NONE);
        clear_scan();
    endfunction

    always @(posedge clk or negedge rst_n) begin
        token_t want;
        if (!rst_n) begin
            first_line = 1'b0;
            first_col = 1'b0;
            clear_scan();
            token_q.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == stok_pkg::REG_FIRST_LINE) first_line = pwdata[0];
                else first_col = pwdata[0];
                if (pos == '0) begin
                    line = 24'(first_line);
                    col = 16'(first_col);
                end
            end
            if (in_valid && in_ready) begin
                step_tokens.delete();
                if (is_end) scan_end();
                else scan_byte(byte_value);
                if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].fin = 1'b1;
                foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
            end
            if (out_valid && out_ready) begin
                if (token_q.size() == 0) begin
                    $display("%0t: unexpected token kind %0d at index %0d", $time,
                             token_kind, start_index);
                    errors++;
                end else begin
                    want = token_q.pop_front();
                    if (want.kind !== token_kind || want.lit !== literal_kind ||
                        want.s_idx !== start_index || want.e_idx !== end_index ||
                        want.s_line !== head_line || want.s_col !== head_column ||
                        want.e_line !== tail_line || want.e_col !== tail_column ||
                        want.fin !== last) begin
                        $display("%0t: token mismatch expected %0d/%0d %0d-%0d %0d:%0d-%0d:%0d l%0b",
                                 $time, want.kind, want.lit, want.s_idx, want.e_idx,
                                 want.s_line, want.s_col, want.e_line, want.e_col, want.fin);
                        $display("%0t:                 actual %0d/%0d %0d-%0d %0d:%0d-%0d:%0d l%0b",
                                 $time, token_kind, literal_kind, start_index, end_index,
                                 head_line, head_column, tail_line, tail_column, last);
                        errors++;
                    end
                end
            end
        end
        pending = token_q.size();
    end

endmodule

// File: tb/sv/tb_source_tokenizer_unit.sv
// Testbench top for source_tokenizer_unit: drives bytes, end markers and register
// writes with random idling and gives the verdict. Depends on stok_pkg and stok_checker.
`timescale 1ns / 1ps

module tb_source_tokenizer_unit;

    localparam int CycleLimit = 400000;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic [7:0]  byte_value;
    logic        is_end;
    logic        out_valid, out_ready;
    logic [6:0]  token_kind;
    logic [2:0]  literal_kind;
    logic [23:0] start_index, end_index, head_line, tail_line;
    logic [15:0] head_column, tail_column;
    logic        last;
    int          errors, pending;
    int          idle_in, idle_out;
    int          cycles;
    bit          hold_off;
    string       keywords[8] = '{"fun", "continue", "domain", "of", "switch", "if",
                                 "until", "return"};
    string       op_chars = "|<>=!&+-/*%.:~,;{}()[]@\\";

    source_tokenizer_unit i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .byte_value(byte_value),
        .is_end(is_end), .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .literal_kind(literal_kind),
        .start_index(start_index), .end_index(end_index), .head_line(head_line),
        .head_column(head_column), .tail_line(tail_line), .tail_column(tail_column),
        .last(last)
    );

    stok_checker i_checker (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .byte_value(byte_value),
        .is_end(is_end), .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .literal_kind(literal_kind),
        .start_index(start_index), .end_index(end_index), .head_line(head_line),
        .head_column(head_column), .tail_line(tail_line), .tail_column(tail_column),
        .last(last), .errors(errors), .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("source_tokenizer_unit verification failed");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= !hold_off && ($urandom_range(0, 99) >= idle_out);
    end

    task automatic put(logic [7:0] b, logic e);
        if ($urandom_range(0, 99) < idle_in) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_in);
        end
        in_valid <= 1'b1;
        byte_value <= b;
        is_end <= e;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic reg_write(logic [0:0] idx, logic val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_word(int n);
        put(($urandom_range(0, 9) == 0) ? "_" : 8'("a" + $urandom_range(0, 25)), 1'b0);
        for (int i = 1; i < n; i++)
            case ($urandom_range(0, 3))
                0: put(8'("0" + $urandom_range(0, 9)), 1'b0);
                1: put(8'("A" + $urandom_range(0, 25)), 1'b0);
                default: put(8'("a" + $urandom_range(0, 25)), 1'b0);
            endcase
    endtask

    task automatic random_piece();
        int n;
        case ($urandom_range(0, 15))
            0, 1: put_text(keywords[$urandom_range(0, 7)]);
            2: random_word($urandom_range(1, 12));
            3: begin
                n = $urandom_range(1, 4);
                repeat (n) put(8'("0" + $urandom_range(0, 9)), 1'b0);
                if ($urandom_range(0, 1)) begin
                    put(".", 1'b0);
                    repeat ($urandom_range(0, 3)) put(8'("0" + $urandom_range(0, 9)), 1'b0);
                end
            end
            4, 5: begin
                put(op_chars[$urandom_range(0, op_chars.len() - 1)], 1'b0);
                put(op_chars[$urandom_range(0, op_chars.len() - 1)], 1'b0);
            end
            6: begin
                put("\"", 1'b0);
                repeat ($urandom_range(0, 5))
                    case ($urandom_range(0, 3))
                        0: put_text("\\\"");
                        1: put("\\", 1'b0);
                        default: put(8'($urandom_range(32, 126)), 1'b0);
                    endcase
                case ($urandom_range(0, 5))
                    0: put(8'h0A, 1'b0);
                    1: ;
                    default: put("\"", 1'b0);
                endcase
            end
            7: begin
                put("'", 1'b0);
                case ($urandom_range(0, 3))
                    0: put("\\", 1'b0);
                    1: put("'", 1'b0);
                    default: ;
                endcase
                if ($urandom_range(0, 3) != 0) put(8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 3) != 0) put("'", 1'b0);
            end
            8: begin
                put("#", 1'b0);
                repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)), 1'b0);
                put(8'h0A, 1'b0);
            end
            9: put(8'h0A, 1'b0);
            10, 11: put(8'($urandom_range(0, 255)), 1'b0);
            12: begin
                put(8'hC2, 1'b0);
                if ($urandom_range(0, 1)) put(8'hAC, 1'b0);
            end
            13: put_text("1..2");
            default: put(($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : " ", 1'b0);
        endcase
        if ($urandom_range(0, 2) == 0) put(" ", 1'b0);
        if ($urandom_range(0, 60) == 0) put(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic random_phase(int count);
        repeat (count / 3) random_piece();
        put(8'h00, 1'b1);
    endtask

    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        byte_value = '0;
        is_end = 1'b0;
        idle_in = 35;
        idle_out = 62;
        hold_off = 1'b0;
        cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_write(stok_pkg::REG_FIRST_LINE, 1'b1);
        reg_write(stok_pkg::REG_FIRST_COL, 1'b1);
        put_text("fun continue continues x_1\n1..2 \"a\\\"b\" 'c' '' |!=> ");
        put(8'hC2, 1'b0);
        put(8'hAC, 1'b0);
        put(8'hC2, 1'b0);
        put(8'hFF, 1'b0);
        put(8'h00, 1'b0);
        put_text("\"x");
        put(8'hFF, 1'b1);
        drain();

        reg_write(stok_pkg::REG_FIRST_LINE, 1'b0);
        reg_write(stok_pkg::REG_FIRST_COL, 1'b0);
        random_phase(570);
        drain();

        idle_in = 62;
        idle_out = 35;
        reg_write(stok_pkg::REG_FIRST_LINE, 1'b1);
        reg_write(stok_pkg::REG_FIRST_COL, 1'b0);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        random_phase(570);
        drain();

        idle_in = 0;
        idle_out = 0;
        reg_write(stok_pkg::REG_FIRST_LINE, 1'b0);
        reg_write(stok_pkg::REG_FIRST_COL, 1'b1);
        random_phase(280);
        drain();
        random_phase(280);
        drain();

        if (errors == 0 && pending == 0)
            $display("source_tokenizer_unit verification clean");
        else
            $display("source_tokenizer_unit verification failed");
        $finish;
    end

endmodule
